// ===== src/fit_placement_allocator_core_defines.svh =====
// assertion macros shared by the allocator modules
// no dependencies; each use expects clk and rst_n in scope
`ifndef FIT_PLACEMENT_ALLOCATOR_CORE_DEFINES_SVH
`define FIT_PLACEMENT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define FPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpa check failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpa check failed");

`endif

// ===== src/fpa_pkg.sv =====
// shared types and constants of the fit placement allocator
// no dependencies
package fpa_pkg;

    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 4'd1;

    localparam logic [4:0] BLOCKS_IN_USE_RESET = 5'd16;

    // opcodes of an input word
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fpa_state_t;

    typedef struct packed {
        logic                opcode;
        logic [SLOT_W-1:0]   block_slot;
        logic [AMOUNT_W-1:0] amount;
    } req_word_t;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   chosen_block;
        logic [AMOUNT_W-1:0] leftover;
    } rsp_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // write one block size, clear rover
        logic start;   // latch request and scan setup
        logic issue;   // read one table entry and advance
        logic finish;  // commit placement and load result
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;  // every taking-part block has been read
        logic rsp_hold;   // result register full and stalled
    } ctl_sts_t;

endpackage

// ===== src/fpa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/fpa_datapath.sv =====
// datapath: config registers, free space table, scan and pick registers, result register
// depends on fpa_pkg, fpa_ram and fit_placement_allocator_core_defines.svh
`include "fit_placement_allocator_core_defines.svh"

module fpa_datapath #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fpa_pkg::ctl_cmd_t                cmd,
    output fpa_pkg::ctl_sts_t                sts,
    input  fpa_pkg::req_word_t               req_word,
    input  logic                             cfg_valid,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             rsp_stall,
    output logic                             rsp_valid,
    output fpa_pkg::rsp_word_t               rsp_word
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int AMOUNT_W_L = fpa_pkg::AMOUNT_W;

    // configuration
    fpa_pkg::fit_mode_t fit_mode_reg;
    logic [4:0]         blocks_reg;

    // scan state
    logic [AW-1:0]        rover_reg, rover_next;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        cnt_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        ev_addr_reg;
    logic                 ev_valid_reg;
    logic [AMOUNT_W_L-1:0] need_reg;
    logic                 pick_valid_reg;
    logic [AW-1:0]        pick_addr_reg;
    logic [SIZE_BITS-1:0] pick_val_reg;

    // result
    logic                 rsp_valid_reg;
    fpa_pkg::rsp_word_t   rsp_word_reg;

    // combinational helpers
    logic [31:0]          blocks_ext;
    logic [31:0]          n_eff;
    logic [CW-1:0]        n_start;
    logic [AW-1:0]        start_addr;
    logic [31:0]          slot_ext;
    logic [31:0]          amount_ext;
    logic                 slot_ok;
    logic [AW-1:0]        addr_adv;
    logic [SIZE_BITS-1:0] rd_data;
    logic [31:0]          rd_ext;
    logic [31:0]          need_ext;
    logic [31:0]          pick_ext;
    logic                 hit;
    logic                 take;
    logic [SIZE_BITS-1:0] left_val;
    logic [31:0]          left_ext;
    logic [31:0]          pick_addr_ext;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= fpa_pkg::FIT_FIRST;
            blocks_reg   <= fpa_pkg::BLOCKS_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fpa_pkg::CFG_FIT_MODE:      fit_mode_reg <= fpa_pkg::fit_mode_t'(cfg_data[1:0]);
                fpa_pkg::CFG_BLOCKS_IN_USE: blocks_reg   <= cfg_data[4:0];
                default:                    ;
            endcase
        end
    end

    // effective block count and scan start
    always_comb
    begin
        blocks_ext = 32'(blocks_reg);
        n_eff      = (blocks_ext > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS) : blocks_ext;
        n_start    = n_eff[CW-1:0];
        if (fit_mode_reg == fpa_pkg::FIT_NEXT && 32'(rover_reg) < n_eff)
        begin
            start_addr = rover_reg;
        end
        else
        begin
            start_addr = '0;
        end
        slot_ext   = 32'(req_word.block_slot);
        amount_ext = 32'(req_word.amount);
        slot_ok    = slot_ext < 32'(NUM_BLOCKS);
        addr_adv   = (32'(addr_reg) + 32'd1 == 32'(n_reg)) ? '0 : addr_reg + AW'(1);
    end

    // compare the entry read last cycle against the pick so far
    always_comb
    begin
        rd_ext   = 32'(rd_data);
        need_ext = 32'(need_reg);
        pick_ext = 32'(pick_val_reg);
        hit      = ev_valid_reg && (rd_ext >= need_ext);
        take     = hit && (!pick_valid_reg
                        || (fit_mode_reg == fpa_pkg::FIT_BEST  && rd_ext < pick_ext)
                        || (fit_mode_reg == fpa_pkg::FIT_WORST && rd_ext > pick_ext));
        left_ext      = pick_ext - need_ext;
        left_val      = left_ext[SIZE_BITS-1:0];
        pick_addr_ext = 32'(pick_addr_reg);
    end

    // table write: load from idle, commit at finish
    always_comb
    begin
        if (cmd.finish)
        begin
            ram_we    = pick_valid_reg;
            ram_waddr = pick_addr_reg;
            ram_wdata = left_val;
        end
        else
        begin
            ram_we    = cmd.load && slot_ok;
            ram_waddr = slot_ext[AW-1:0];
            ram_wdata = amount_ext[SIZE_BITS-1:0];
        end
    end

    fpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.issue),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rover_next = rover_reg;
        if (cmd.load)
        begin
            rover_next = '0;
        end
        else if (cmd.finish && pick_valid_reg && fit_mode_reg == fpa_pkg::FIT_NEXT)
        begin
            rover_next = pick_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rover_reg      <= '0;
            n_reg          <= '0;
            cnt_reg        <= '0;
            addr_reg       <= '0;
            ev_addr_reg    <= '0;
            ev_valid_reg   <= 1'b0;
            pick_valid_reg <= 1'b0;
            pick_addr_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rover_reg    <= rover_next;
            ev_valid_reg <= cmd.issue;
            if (cmd.issue)
            begin
                ev_addr_reg <= addr_reg;
                addr_reg    <= addr_adv;
                cnt_reg     <= cnt_reg + CW'(1);
            end
            if (cmd.start)
            begin
                n_reg          <= n_start;
                cnt_reg        <= '0;
                addr_reg       <= start_addr;
                pick_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                pick_valid_reg <= 1'b1;
                pick_addr_reg  <= ev_addr_reg;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            need_reg <= req_word.amount;
        end
        if (take)
        begin
            pick_val_reg <= rd_data;
        end
        if (cmd.finish)
        begin
            rsp_word_reg.granted <= pick_valid_reg;
            if (pick_valid_reg)
            begin
                rsp_word_reg.chosen_block <= pick_addr_ext[fpa_pkg::SLOT_W-1:0];
                rsp_word_reg.leftover     <= AMOUNT_W_L'(32'(left_val));
            end
            else
            begin
                rsp_word_reg.chosen_block <= '0;
                rsp_word_reg.leftover     <= '0;
            end
        end
    end

    assign sts.scan_done = (cnt_reg == n_reg);
    assign sts.rsp_hold  = rsp_valid_reg && rsp_stall;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp_word      = rsp_word_reg;

    `FPA_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= n_reg)
    `FPA_ASSERT_SAME(a_pick_in_range, pick_valid_reg, 32'(pick_addr_reg) < 32'(n_reg))
    `FPA_ASSERT_NEXT(a_load_clears_rover, cmd.load, rover_reg == '0)

endmodule

// ===== src/fpa_controller.sv =====
// controller: sequences load, scan and commit of each input word
// depends on fpa_pkg and fit_placement_allocator_core_defines.svh
`include "fit_placement_allocator_core_defines.svh"

module fpa_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  fpa_pkg::req_word_t req_word,
    output fpa_pkg::ctl_cmd_t  cmd,
    input  fpa_pkg::ctl_sts_t  sts
);

    fpa_pkg::fpa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (req_word.opcode == fpa_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = fpa_pkg::ST_SCAN;
                    end
                end
            end
            fpa_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = fpa_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            fpa_pkg::ST_FINISH:
            begin
                if (!sts.rsp_hold)
                begin
                    cmd.finish = 1'b1;
                    state_next = fpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
        endcase
    end

    `FPA_ASSERT_NEXT(a_alloc_starts_scan,
        req_valid && !req_stall && req_word.opcode == fpa_pkg::OP_ALLOC,
        state_reg == fpa_pkg::ST_SCAN)
    `FPA_ASSERT_NEXT(a_scan_end_to_finish,
        state_reg == fpa_pkg::ST_SCAN && sts.scan_done,
        state_reg == fpa_pkg::ST_FINISH)
    `FPA_ASSERT_SAME(a_no_overwrite, cmd.finish, !sts.rsp_hold)

endmodule

// ===== src/fit_placement_allocator_core.sv =====
// top level of the fit placement allocator: controller plus datapath
// depends on fpa_pkg, fpa_controller, fpa_datapath, fpa_ram

// Placement engine over a table of NUM_BLOCKS free-space entries of SIZE_BITS bits.
// A load word writes one block size (slots at or beyond NUM_BLOCKS write
// nothing) and returns the next-fit pointer to block 0; it gives no result. A
// request word goes from acceptance to the result register through a setup
// step, one table read per block through the single read port of the table ram,
// a last compare, and a commit that writes the shrunk entry back and loads the
// result. Here n is the effective block count (min of blocks_in_use and
// NUM_BLOCKS); every request scans all n blocks whatever the fit mode, so the
// latency does not depend on the data. The input side is stalled for the whole
// request and open again once the result is loaded; a finished result waits in
// its own register, so the next word is taken while it is still unread. The
// commit waits only if an earlier result is still stalled there. Config writes
// are taken every cycle (cfg_ready stays high) and must only be made while idle.
// Entries never loaded read as undefined.

module fit_placement_allocator_core #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           req_valid,
    output logic                           req_stall,
    input  fpa_pkg::req_word_t             req_word,
    // result words
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output fpa_pkg::rsp_word_t             rsp_word,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data
);

    fpa_pkg::ctl_cmd_t cmd;
    fpa_pkg::ctl_sts_t sts;

    // config registers sit in the datapath and never push back
    assign cfg_ready = 1'b1;

    fpa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .cmd       (cmd),
        .sts       (sts)
    );

    fpa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_word  (req_word),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word)
    );

endmodule
